@@ hdl/nqts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nqts_pkg
// Shared constants and types for the note queue tone sequencer.
// ----------------------------------------------------------------------------
package nqts_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TONE_W  = 16;
  localparam int DUR_W   = 16;
  localparam int QLEV_W  = 5;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // item accepted, capture a result
    logic accepted;  // accepted flag of the result
    logic push;      // write a note into the queue
    logic tick_en;   // enabled tick: count down the current note
    logic pop;       // start the next note from the queue
  } nqts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic playing;
    logic ms_last;   // current note ends on the next enabled tick
  } nqts_stat_t;

endpackage
`default_nettype wire

@@ hdl/nqts_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nqts_in_if
// Input item channel: push a note or one millisecond tick.
// ----------------------------------------------------------------------------
interface nqts_in_if
  import nqts_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TONE_W-1:0] tone_hz;
  logic [DUR_W-1:0]  duration_ms;

  modport source (output valid, output kind, output tone_hz, output duration_ms,
                  input ready);
  modport sink   (input valid, input kind, input tone_hz, input duration_ms,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/nqts_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nqts_out_if
// Result item channel: one result per input item.
// ----------------------------------------------------------------------------
interface nqts_out_if
  import nqts_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              tone_on;
  logic [TONE_W-1:0] tone_hz_out;
  logic              note_started;
  logic [QLEV_W-1:0] queue_level;

  modport source (output valid, output accepted, output tone_on, output tone_hz_out,
                  output note_started, output queue_level, input ready);
  modport sink   (input valid, input accepted, input tone_on, input tone_hz_out,
                  input note_started, input queue_level, output ready);
endinterface
`default_nettype wire

@@ hdl/nqts_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nqts_ctrl
// Handshake control, playback enable register and command decode.
// ----------------------------------------------------------------------------
module nqts_ctrl
  import nqts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_kind,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire nqts_stat_t stat,
  output nqts_cmd_t       cmd
);

  logic enabled_r, enabled_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic note_end;

  // result register frees up when empty or being taken
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    enabled_nxt = cfg_we ? cfg_wdata : enabled_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign note_end = !stat.playing || stat.ms_last;

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.push     = accept && (in_kind == KIND_PUSH) && !stat.full;
    cmd.accepted = (in_kind == KIND_TICK) || !stat.full;
    cmd.tick_en  = accept && (in_kind == KIND_TICK) && enabled_r;
    cmd.pop      = cmd.tick_en && note_end && !stat.empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      enabled_r   <= enabled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/nqts_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nqts_dpath
// Note queue, note countdown and tone state, plus the result register.
// ----------------------------------------------------------------------------
module nqts_dpath
  import nqts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nqts_cmd_t         cmd,
  output nqts_stat_t             stat,
  input  wire logic [TONE_W-1:0] in_tone_hz,
  input  wire logic [DUR_W-1:0]  in_duration_ms,
  output logic                   out_accepted,
  output logic                   out_tone_on,
  output logic [TONE_W-1:0]      out_tone_hz_out,
  output logic                   out_note_started,
  output logic [QLEV_W-1:0]      out_queue_level
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(QUEUE_DEPTH);

  logic [TONE_W-1:0] q_tone [QUEUE_DEPTH];
  logic [DUR_W-1:0]  q_dur  [QUEUE_DEPTH];

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [LVL_W-1:0]  fill_r, fill_nxt;
  logic              playing_r, playing_nxt;
  logic              sounding_r, sounding_nxt;
  logic [DUR_W-1:0]  ms_r, ms_nxt;
  logic [TONE_W-1:0] cur_tone_r, cur_tone_nxt;

  logic [TONE_W-1:0] head_tone_r;
  logic [DUR_W-1:0]  head_dur_r;
  logic [LVL_W+QLEV_W-1:0] fill_ext;

  logic              acc_r;
  logic              tone_on_r;
  logic [TONE_W-1:0] tone_out_r;
  logic              started_r;
  logic [QLEV_W-1:0] level_r;

  assign stat.full    = (fill_r == LVL_FULL);
  assign stat.empty   = (fill_r == '0);
  assign stat.playing = playing_r;
  assign stat.ms_last = (ms_r[DUR_W-1:1] == '0);

  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    fill_nxt     = fill_r;
    playing_nxt  = playing_r;
    sounding_nxt = sounding_r;
    ms_nxt       = ms_r;
    cur_tone_nxt = cur_tone_r;

    if (cmd.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      fill_nxt   = fill_r + 1'b1;
    end

    // countdown saturates at zero; note ends on the enabled tick that leaves it at zero
    if (cmd.tick_en && playing_r) begin
      ms_nxt = (ms_r != '0) ? ms_r - 1'b1 : '0;
      if (ms_r[DUR_W-1:1] == '0) begin
        playing_nxt  = 1'b0;
        sounding_nxt = 1'b0;
      end
    end

    if (cmd.pop) begin
      rd_ptr_nxt   = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      fill_nxt     = fill_r - 1'b1;
      ms_nxt       = head_dur_r;
      playing_nxt  = 1'b1;
      cur_tone_nxt = head_tone_r;
      sounding_nxt = (head_tone_r != '0);
    end
  end

  assign fill_ext = {{QLEV_W{1'b0}}, fill_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      fill_r     <= '0;
      playing_r  <= 1'b0;
      sounding_r <= 1'b0;
      ms_r       <= '0;
      cur_tone_r <= '0;
    end else begin
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      fill_r     <= fill_nxt;
      playing_r  <= playing_nxt;
      sounding_r <= sounding_nxt;
      ms_r       <= ms_nxt;
      cur_tone_r <= cur_tone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      q_tone[wr_ptr_r] <= in_tone_hz;
      q_dur[wr_ptr_r]  <= in_duration_ms;
    end
    // head of the queue for the next item; a push into that slot goes straight through
    if (cmd.push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_tone_r <= in_tone_hz;
      head_dur_r  <= in_duration_ms;
    end else begin
      head_tone_r <= q_tone[rd_ptr_nxt];
      head_dur_r  <= q_dur[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r      <= cmd.accepted;
      tone_on_r  <= sounding_nxt;
      tone_out_r <= sounding_nxt ? cur_tone_nxt : '0;
      started_r  <= cmd.pop;
      level_r    <= fill_ext[QLEV_W-1:0];
    end
  end

  assign out_accepted     = acc_r;
  assign out_tone_on      = tone_on_r;
  assign out_tone_hz_out  = tone_out_r;
  assign out_note_started = started_r;
  assign out_queue_level  = level_r;

endmodule
`default_nettype wire

@@ hdl/note_queue_tone_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// note_queue_tone_sequencer
// Note FIFO with a millisecond-tick driven tone sequencer.
// ----------------------------------------------------------------------------
// Takes one item per clock while no result waits: a push (kind 0) queues a
// note of tone_hz and duration_ms into a 16-deep FIFO, a tick (kind 1) is one
// elapsed millisecond that counts the current note down and starts the next
// one when it ends. Each item yields one result in the cycle after it is taken,
// registered with the queue, note counter and tone state. There is one result
// register: while a result waits the input is held off, and the next item is
// taken in the same cycle that the waiting result is taken. Ticks do nothing
// until cfg_wdata 1 is written with cfg_we; pushes are taken at any time.
// ----------------------------------------------------------------------------
module note_queue_tone_sequencer
  import nqts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  nqts_in_if.sink   in_ch,
  nqts_out_if.source out_ch
);

  nqts_cmd_t  cmd;
  nqts_stat_t stat;

  nqts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_kind   (in_ch.kind),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nqts_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_tone_hz       (in_ch.tone_hz),
    .in_duration_ms   (in_ch.duration_ms),
    .out_accepted     (out_ch.accepted),
    .out_tone_on      (out_ch.tone_on),
    .out_tone_hz_out  (out_ch.tone_hz_out),
    .out_note_started (out_ch.note_started),
    .out_queue_level  (out_ch.queue_level)
  );

endmodule
`default_nettype wire
